### hdl/plsl_pkg.sv
// ----------------------------------------------------------------------------
// plsl_pkg
// Shared widths, register indexes and codes of the stiffness lookup.
// ----------------------------------------------------------------------------
package plsl_pkg;

  // default table depth
  localparam int MAX_POINTS_DEF = 16;

  // payload widths
  localparam int IDX_W   = 4;
  localparam int POS_W   = 31;
  localparam int STIFF_W = 32;
  localparam int SUM_W   = 32;
  localparam int NP_W    = 5;
  localparam int FAC_W   = 20;
  localparam int STAT_W  = 2;

  // configuration port
  localparam int REG_W  = 2;
  localparam int CFG_DW = 20;
  localparam logic [REG_W-1:0] REG_NUM_POINTS = 2'd0;
  localparam logic [REG_W-1:0] REG_RESIDUAL   = 2'd1;
  localparam logic [REG_W-1:0] REG_SCALE      = 2'd2;

  // Q4.16 one
  localparam logic [FAC_W-1:0] Q_ONE = 20'd65536;

  // item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOSEG = 2'd2;

  // serial divider: 64-bit dividend, 31-bit divisor, quotient known below 2^33
  localparam int DVD_W = 64;
  localparam int DVS_W = 31;
  localparam int DQ_W  = 33;

endpackage

### hdl/plsl_ifs.sv
// ----------------------------------------------------------------------------
// plsl_ifs
// Valid/ready channels of the stiffness lookup: request, result, config.
// ----------------------------------------------------------------------------
interface plsl_req_if;
  import plsl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [IDX_W-1:0]           point_index;
  logic [POS_W-1:0]           point_position;
  logic signed [STIFF_W-1:0]  point_stiffness;
  logic signed [SUM_W-1:0]    plastic_sum;

  modport source (output valid, mode, point_index, point_position, point_stiffness,
                  plastic_sum, input ready);
  modport sink   (input valid, mode, point_index, point_position, point_stiffness,
                  plastic_sum, output ready);
endinterface

interface plsl_rsp_if;
  import plsl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [STIFF_W-1:0]  stiffness;
  logic [STAT_W-1:0]          status;

  modport source (output valid, stiffness, status, input ready);
  modport sink   (input valid, stiffness, status, output ready);
endinterface

interface plsl_cfg_if;
  import plsl_pkg::*;
  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/plsl_ram.sv
// ----------------------------------------------------------------------------
// plsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/plsl_div.sv
// ----------------------------------------------------------------------------
// plsl_div
// Restoring divider, one quotient bit per cycle, for a quotient below 2^33.
// ----------------------------------------------------------------------------
module plsl_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [plsl_pkg::DVD_W-1:0] dividend,
  input  logic [plsl_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [plsl_pkg::DQ_W-1:0]  quot
);
  import plsl_pkg::*;

  localparam int CW = $clog2(DQ_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DQ_W-1:0]  low;     // dividend bits going out, quotient bits coming in
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one trial subtract
  always_comb begin
    trial = {rem, low[DQ_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DQ_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath; top bits of the dividend are already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DVD_W-1:DQ_W];
      low <= dividend[DQ_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      low <= {low[DQ_W-2:0], ge};
    end
  end

  assign quot = low;

endmodule

### hdl/piecewise_linear_stiffness_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_stiffness_lookup
// Breakpoint table in two RAMs, segment scan, interpolation with a serial
// divider and Q4.16 scaling with saturation.
// ----------------------------------------------------------------------------
//  port  | dir  | carries
//  ------+------+---------------------------------------------------------
//  cfg   | in   | register writes: num_points, residual_ratio, scale_factor
//  req   | in   | load (write a breakpoint) or query (plastic_sum)
//  rsp   | out  | stiffness and status, one item per query
//
// A load writes both table RAMs as it is accepted. A query reads the
// last entry, then scans entries 0..n-1 at one RAM read per cycle; an
// interpolated hit goes on through a multiply state and the serial
// divider, and a scaled result through the scale and finish states,
// before the delivery state.
// Synchronous reset clears control only; table contents are undefined until
// loaded. A result that is not taken holds the block in its delivery state.
// ----------------------------------------------------------------------------
module piecewise_linear_stiffness_lookup #(
  parameter int MAX_POINTS = plsl_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  plsl_cfg_if.sink    cfg,
  plsl_req_if.sink    req,
  plsl_rsp_if.source  rsp
);
  import plsl_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LAST = 9'b000000010,
    ST_SCAN = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_SCL  = 9'b000100000,
    ST_FIN  = 9'b001000000,
    ST_PUT  = 9'b010000000,
    ST_HOLD = 9'b100000000
  } state_t;

  // configuration registers
  logic [NP_W-1:0]  num_points;
  logic [FAC_W-1:0] residual_ratio;
  logic [FAC_W-1:0] scale_factor;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points     <= NP_W'(1);
      residual_ratio <= Q_ONE;
      scale_factor   <= Q_ONE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_NUM_POINTS: num_points     <= cfg.data[NP_W-1:0];
        REG_RESIDUAL:   residual_ratio <= cfg.data[FAC_W-1:0];
        REG_SCALE:      scale_factor   <= cfg.data[FAC_W-1:0];
        default:        ;
      endcase
    end
  end

  // last entry in use, with the count clamped to 1..MAX_POINTS
  logic [AW-1:0] n_m1;
  always_comb begin
    if (num_points == '0) begin
      n_m1 = '0;
    end else if (32'(num_points) > MAX_POINTS) begin
      n_m1 = AW'(MAX_POINTS - 1);
    end else begin
      n_m1 = AW'(num_points - NP_W'(1));
    end
  end

  logic ovr;
  assign ovr = scale_factor != Q_ONE;

  // state
  state_t st;
  logic [AW-1:0]             chk_idx;
  logic signed [SUM_W-1:0]   s_q;
  logic                      above;
  logic signed [STIFF_W-1:0] k_last;
  logic signed [STIFF_W-1:0] k0;
  logic [POS_W-1:0]          x_prev;
  logic signed [STIFF_W-1:0] y_prev;
  logic                      dy_neg;
  logic [STIFF_W:0]          dy_mag;
  logic [POS_W-1:0]          dx;
  logic [POS_W-1:0]          den;
  logic signed [STIFF_W+1:0] op;
  logic [FAC_W-1:0]          fac;
  logic signed [STIFF_W+FAC_W+2:0] sprod;
  logic signed [STIFF_W-1:0] res_k;
  logic [STAT_W-1:0]         res_stat;

  // table RAMs
  logic                      tbl_we;
  logic [AW-1:0]             tbl_waddr;
  logic [AW-1:0]             tbl_raddr;
  logic [POS_W-1:0]          pos_rd;
  logic [STIFF_W-1:0]        stf_rd;

  assign req.ready = st == ST_IDLE;
  assign tbl_we    = req.valid && req.ready && req.mode == MODE_LOAD
                     && 32'(req.point_index) < MAX_POINTS;
  assign tbl_waddr = AW'(req.point_index);

  always_comb begin
    case (st)
      ST_IDLE: tbl_raddr = n_m1;
      ST_SCAN: tbl_raddr = chk_idx + 1'b1;
      default: tbl_raddr = '0;
    endcase
  end

  plsl_ram #(.WIDTH(POS_W), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (req.point_position),
    .raddr (tbl_raddr),
    .rdata (pos_rd)
  );

  plsl_ram #(.WIDTH(STIFF_W), .DEPTH(MAX_POINTS)) u_stf_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (req.point_stiffness),
    .raddr (tbl_raddr),
    .rdata (stf_rd)
  );

  // divider
  logic               div_start;
  logic               div_done;
  logic [DQ_W-1:0]    div_quot;
  logic [DVD_W-1:0]   div_dvd;

  assign div_start = st == ST_MUL;
  assign div_dvd   = DVD_W'(dy_mag * dx);

  plsl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (den),
    .done     (div_done),
    .quot     (div_quot)
  );

  // scan compares
  logic signed [STIFF_W-1:0] y_cur;
  logic signed [SUM_W-1:0]   xc_s;
  logic signed [SUM_W-1:0]   xp_s;
  logic signed [STIFF_W-1:0] k0v;
  logic                      seg_hit;
  logic                      last_hit;
  logic signed [STIFF_W:0]   dy;
  logic [SUM_W-1:0]          dxw;
  logic [POS_W-1:0]          denw;

  always_comb begin
    y_cur    = $signed(stf_rd);
    xc_s     = $signed({1'b0, pos_rd});
    xp_s     = $signed({1'b0, x_prev});
    k0v      = (chk_idx == '0) ? y_cur : k0;
    seg_hit  = chk_idx != '0 && s_q >= xp_s && s_q < xc_s;
    last_hit = chk_idx == n_m1 && s_q == xc_s && pos_rd != '0;
    dy       = {y_cur[STIFF_W-1], y_cur} - {y_prev[STIFF_W-1], y_prev};
    dxw      = s_q - xp_s;
    denw     = pos_rd - x_prev;
  end

  // interpolation sum and final scaling
  logic signed [DQ_W:0]            q_s;
  logic signed [STIFF_W+1:0]       interp;
  logic signed [STIFF_W+FAC_W+2:0] sadj;
  logic signed [STIFF_W+FAC_W-14:0] shq;
  logic signed [STIFF_W-1:0]       sat_k;

  always_comb begin
    q_s    = dy_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    interp = $signed({{2{y_prev[STIFF_W-1]}}, y_prev}) + q_s;
    sadj   = sprod[STIFF_W+FAC_W+2] ? sprod + (STIFF_W+FAC_W+3)'(65535) : sprod;
    shq    = sadj[STIFF_W+FAC_W+2:16];
    if (shq > $signed((STIFF_W+FAC_W-13)'(32'h7FFFFFFF))) begin
      sat_k = 32'sh7FFFFFFF;
    end else if (shq < -$signed((STIFF_W+FAC_W-13)'(33'h080000000))) begin
      sat_k = 32'sh80000000;
    end else begin
      sat_k = shq[STIFF_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_IDLE;
      chk_idx <= '0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (req.valid && req.mode == MODE_QUERY) begin
            st <= ST_LAST;
          end
        end
        ST_LAST: begin
          chk_idx <= '0;
          st      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (above) begin
            st <= ST_SCL;
          end else if (seg_hit) begin
            if (s_q == xp_s) begin
              st <= ST_PUT;
            end else if (ovr) begin
              st <= ST_SCL;
            end else begin
              st <= ST_MUL;
            end
          end else if (last_hit) begin
            st <= ST_PUT;
          end else if (chk_idx == n_m1) begin
            st <= ST_SCL;
          end else begin
            chk_idx <= chk_idx + 1'b1;
          end
        end
        ST_MUL:  st <= ST_DIV;
        ST_DIV:  if (div_done) st <= ST_SCL;
        ST_SCL:  st <= ST_FIN;
        ST_FIN:  st <= ST_PUT;
        ST_PUT:  if (!rsp.valid || rsp.ready) st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: s_q <= req.plastic_sum;
      ST_LAST: begin
        above  <= s_q > xc_s;
        k_last <= y_cur;
      end
      ST_SCAN: begin
        if (chk_idx == '0) begin
          k0 <= y_cur;
        end
        if (above) begin
          op       <= ovr ? (STIFF_W+2)'(y_cur) : (STIFF_W+2)'(k_last);
          fac      <= ovr ? scale_factor : residual_ratio;
          res_stat <= STAT_OK;
        end else if (seg_hit) begin
          res_stat <= STAT_OK;
          res_k    <= y_prev;
          op       <= (STIFF_W+2)'(k0v);
          fac      <= scale_factor;
          dy_neg   <= dy[STIFF_W];
          dy_mag   <= dy[STIFF_W] ? (STIFF_W+1)'(-dy) : (STIFF_W+1)'(dy);
          dx       <= dxw[POS_W-1:0];
          den      <= denw;
        end else if (last_hit) begin
          res_stat <= STAT_OK;
          res_k    <= y_cur;
        end else if (chk_idx == n_m1) begin
          res_stat <= STAT_NOSEG;
          op       <= ovr ? (STIFF_W+2)'(k0v) : '0;
          fac      <= ovr ? scale_factor : residual_ratio;
        end else begin
          x_prev <= pos_rd;
          y_prev <= y_cur;
        end
      end
      ST_DIV: begin
        op  <= interp;
        fac <= residual_ratio;
      end
      ST_SCL: sprod <= op * $signed({1'b0, fac});
      ST_FIN: res_k <= sat_k;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (st == ST_PUT && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_PUT && (!rsp.valid || rsp.ready)) begin
      rsp.stiffness <= res_k;
      rsp.status    <= res_stat;
    end
  end

`ifndef SYNTHESIS
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.mode == MODE_QUERY) |=> st == ST_LAST)
    else $error("query item did not start a table read");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    st == ST_SCAN |-> chk_idx <= n_m1)
    else $error("scan index beyond last entry in use");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> st == ST_DIV)
    else $error("divider finished outside the divide state");

  a_put_delivers: assert property (@(posedge clk) disable iff (rst)
    (st == ST_PUT && (!rsp.valid || rsp.ready)) |=> rsp.valid && st == ST_IDLE)
    else $error("result not posted on a free output register");
`endif

endmodule
